### rtl/core/isa_pkg.sv
// shared types and constants for the insertion shift array
// operation and status codes, register addresses and reset values, build defaults, per-cell control struct
// no dependencies
package isa_pkg;

  // default build parameters
  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // configuration register addresses (byte addresses)
  localparam logic [2:0] ADDR_CAPACITY    = 3'd0;
  localparam logic [2:0] ADDR_START_INDEX = 3'd4;

  // register reset values
  localparam logic [4:0]  CAPACITY_RST    = 5'd16;
  localparam logic [15:0] START_INDEX_RST = 16'd0;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_APPEND  = 2'd1,
    OP_PREPEND = 2'd2,
    OP_INSERT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // control handed to one cell of the row
  typedef struct packed {
    logic shift;   // take the left neighbor's value
    logic load;    // take the new value
    logic rd_sel;  // drive own value onto the read bus
  } cell_ctl_t;

endpackage

### rtl/core/isa_cell.sv
// one slot of the shift row: holds a value, shifts from its left neighbor
// or loads the new value, and gates its value onto the read bus
// depends on isa_pkg
module isa_cell import isa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_ctl_t              ctl,
  input  logic [VALUE_WIDTH-1:0] shift_in,
  input  logic [VALUE_WIDTH-1:0] load_value,
  output logic [VALUE_WIDTH-1:0] slot_out,
  output logic [VALUE_WIDTH-1:0] read_out
);

  logic [VALUE_WIDTH-1:0] slot_r;
  logic [VALUE_WIDTH-1:0] slot_nxt;

  // load wins over shift; otherwise hold
  always_comb begin
    slot_nxt = slot_r;
    if (ctl.load) begin
      slot_nxt = load_value;
    end else if (ctl.shift) begin
      slot_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_out = slot_r;
  assign read_out = ctl.rd_sel ? slot_r : '0;

endmodule

### rtl/core/insertion_shift_array.sv
// insertion shift array: bounded array list with logical indexing
// top level with request decode, count/base registers, apb registers, cell row
// depends on isa_pkg and isa_cell
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request per transaction:
//   operation, index and value. Result channel (out_valid/out_stall) carries
//   one result per request: read_value, status, element_count, first_index.
//   A request is decoded and applied to the row of cells in the cycle it is
//   accepted; its result sits in the output register from the next cycle on,
//   and throughput is one request per cycle while no result stalls. The
//   rate is set by the parallel shift of the cell row, which moves every
//   slot at once. When the receiver stalls a waiting result, in_stall rises
//   and no further request is taken until the result is accepted.
//   Reset (rst_n low, synchronous) clears every slot, the element count and
//   the output valid, and loads capacity 16 and start index 0.
//   Registers via the apb port: capacity at 0, start_index at 4; a write of
//   start_index also loads the logical index of slot zero. Write registers
//   only while no request is in flight.
module insertion_shift_array import isa_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_index,
  input  logic [31:0] in_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_value,
  output logic [1:0]  out_status,
  output logic [4:0]  out_element_count,
  output logic [31:0] out_first_index,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(DEPTH + 1);

  // registers
  logic [4:0]             capacity_r;
  logic [15:0]            start_index_r;
  logic [CW-1:0]          count_r, count_nxt;
  logic [31:0]            base_r, base_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [31:0]            read_value_r;
  logic [1:0]             status_r;
  logic [4:0]             element_count_r;
  logic [31:0]            first_index_r;

  // decode signals
  logic                   accept;
  logic                   cfg_wr;
  op_t                    op;
  logic [CW-1:0]          cap_eff;
  logic signed [33:0]     idx_s, base_s, diff_s;
  logic signed [33:0]     cap_end_s, cnt_end_s;
  logic                   rd_ok, ins_ok, full, wr;
  logic                   shift_op;
  logic [CW-1:0]          pos;
  logic [CW-1:0]          wr_pos;
  status_t                status;
  logic [VALUE_WIDTH-1:0] new_value;
  logic [VALUE_WIDTH-1:0] rd_or;

  logic [VALUE_WIDTH-1:0] slot_q [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_rd [DEPTH];
  cell_ctl_t              ctl [DEPTH];

  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign op        = op_t'(in_operation);
  assign new_value = VALUE_WIDTH'(in_value);

  // capacity above depth acts as depth
  assign cap_eff = (32'(capacity_r) > DEPTH) ? CW'(DEPTH) : CW'(capacity_r);

  // index window checks over the full signed range
  always_comb begin
    idx_s     = 34'(signed'(in_index));
    base_s    = 34'(signed'(base_r));
    diff_s    = idx_s - base_s;
    cap_end_s = base_s + signed'(34'(cap_eff));
    cnt_end_s = base_s + signed'(34'(count_r));
    rd_ok     = (idx_s >= base_s) && (idx_s < cap_end_s);
    ins_ok    = (idx_s >= base_s) && (idx_s <= cnt_end_s);
    pos       = diff_s[CW-1:0];
  end

  // status and write decision
  always_comb begin
    full     = (count_r >= cap_eff) || (count_r >= CW'(DEPTH));
    status   = ST_OK;
    wr       = 1'b0;
    shift_op = 1'b0;
    wr_pos   = count_r;
    case (op)
      OP_READ: begin
        status = rd_ok ? ST_OK : ST_RANGE;
      end
      OP_APPEND: begin
        status = full ? ST_FULL : ST_OK;
        wr     = !full;
        wr_pos = count_r;
      end
      OP_PREPEND: begin
        status   = full ? ST_FULL : ST_OK;
        wr       = !full;
        shift_op = 1'b1;
        wr_pos   = '0;
      end
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (!ins_ok) begin
          status = ST_RANGE;
        end else begin
          wr = 1'b1;
        end
        shift_op = 1'b1;
        wr_pos   = pos;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // row of cells, each steered by its position against the write point
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      ctl[i].load   = accept && wr && (wr_pos == CW'(i));
      ctl[i].shift  = accept && wr && shift_op && (CW'(i) > wr_pos);
      ctl[i].rd_sel = (op == OP_READ) && rd_ok && (pos == CW'(i));
    end

    if (i == 0) begin : g_head
      isa_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl[i]),
        .shift_in   ('0),
        .load_value (new_value),
        .slot_out   (slot_q[i]),
        .read_out   (cell_rd[i])
      );
    end else begin : g_body
      isa_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl[i]),
        .shift_in   (slot_q[i-1]),
        .load_value (new_value),
        .slot_out   (slot_q[i]),
        .read_out   (cell_rd[i])
      );
    end
  end

  // read bus: at most one cell drives a nonzero value
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  // count and base next values
  always_comb begin
    count_nxt = count_r;
    base_nxt  = base_r;
    if (accept && wr) begin
      count_nxt = count_r + CW'(1);
      if (op == OP_PREPEND) begin
        base_nxt = base_r - 32'd1;
      end
    end
    if (cfg_wr && (paddr[2] == ADDR_START_INDEX[2])) begin
      base_nxt = {{16{pwdata[15]}}, pwdata[15:0]};
    end
  end

  // output handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      base_r        <= {{16{START_INDEX_RST[15]}}, START_INDEX_RST};
      out_valid_r   <= 1'b0;
      capacity_r    <= CAPACITY_RST;
      start_index_r <= START_INDEX_RST;
    end else begin
      count_r     <= count_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && (paddr[2] == ADDR_CAPACITY[2])) begin
        capacity_r <= pwdata[4:0];
      end
      if (cfg_wr && (paddr[2] == ADDR_START_INDEX[2])) begin
        start_index_r <= pwdata[15:0];
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      read_value_r    <= (op == OP_READ && status == ST_OK) ? 32'(rd_or) : 32'd0;
      status_r        <= status;
      element_count_r <= 5'(count_nxt);
      first_index_r   <= base_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = read_value_r;
  assign out_status        = status_r;
  assign out_element_count = element_count_r;
  assign out_first_index   = first_index_r;

  // register readback
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_START_INDEX[2]) ? {16'd0, start_index_r}
                                                    : {27'd0, capacity_r};

endmodule

### dv/tb_insertion_shift_array.sv
// testbench for insertion_shift_array: directed and random requests, register phases
// holds a scoreboard class that predicts each result and checks it in order
// depends on isa_pkg and the insertion_shift_array rtl
module tb_insertion_shift_array;
  import isa_pkg::*;

  localparam int SLOTS = DEPTH_DEF;

  // one result transaction as seen on the out_ ports
  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [4:0]  element_count;
    logic [31:0] first_index;
  } array_result_t;

  // array list predictor plus queue of responses still owed by the block
  class array_list_scoreboard;
    logic [31:0]   slots [SLOTS];
    int unsigned   stored;
    logic [31:0]   base_index;
    logic [4:0]    capacity;
    logic [15:0]   start_reg;
    array_result_t predicted_responses [$];
    int            errors;
    int            checked;
    int            op_seen [4];
    int            status_seen [3];

    function new();
      foreach (slots[k]) slots[k] = '0;
      stored = 0;
      capacity = CAPACITY_RST;
      start_reg = START_INDEX_RST;
      base_index = {{16{start_reg[15]}}, start_reg};
      errors = 0;
      checked = 0;
      foreach (op_seen[k]) op_seen[k] = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    // register write as the block sees it
    function void write_reg(logic [2:0] addr, logic [31:0] data);
      if (addr == ADDR_CAPACITY) begin
        capacity = data[4:0];
      end else if (addr == ADDR_START_INDEX) begin
        start_reg = data[15:0];
        base_index = {{16{data[15]}}, data[15:0]};
      end
    endfunction

    // apply one accepted request and queue the response it owes
    function void apply_request(op_t op, logic [31:0] idx, logic [31:0] val);
      array_result_t r;
      int            usable;
      longint        lo;
      longint        want_idx;
      int            pos;
      usable = (capacity > SLOTS) ? SLOTS : capacity;
      lo = longint'($signed(base_index));
      want_idx = longint'($signed(idx));
      r.read_value = '0;
      r.status = ST_OK;
      if (op == OP_READ) begin
        // read window spans the capacity, not the count
        if (want_idx < lo || want_idx >= lo + usable) r.status = ST_RANGE;
        else r.read_value = slots[want_idx - lo];
      end else if (stored >= usable) begin
        // fullness wins over a bad insert index
        r.status = ST_FULL;
      end else begin
        case (op)
          OP_APPEND: begin
            slots[stored] = val;
            stored++;
          end
          OP_PREPEND: begin
            for (int k = stored; k > 0; k--) slots[k] = slots[k-1];
            slots[0] = val;
            stored++;
            base_index = base_index - 32'd1;
          end
          default: begin
            if (want_idx < lo || want_idx > lo + longint'(stored)) begin
              r.status = ST_RANGE;
            end else begin
              pos = int'(want_idx - lo);
              for (int k = stored; k > pos; k--) slots[k] = slots[k-1];
              slots[pos] = val;
              stored++;
            end
          end
        endcase
      end
      r.element_count = stored[4:0];
      r.first_index = base_index;
      predicted_responses.insert(predicted_responses.size(), r);
      op_seen[op]++;
      status_seen[r.status]++;
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 30)
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    endfunction

    // compare one result transaction with the oldest prediction
    function void check_result(array_result_t got);
      array_result_t want;
      if (predicted_responses.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none actual %h",
                 $time, got);
        return;
      end
      want = predicted_responses.pop_front();
      checked++;
      if (got.read_value !== want.read_value)
        flag("read_value", want.read_value, got.read_value);
      if (got.status !== want.status)
        flag("status", 32'(want.status), 32'(got.status));
      if (got.element_count !== want.element_count)
        flag("element_count", 32'(want.element_count), 32'(got.element_count));
      if (got.first_index !== want.first_index)
        flag("first_index", want.first_index, got.first_index);
    endfunction

    function int pending();
      return predicted_responses.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_READ;
  logic [31:0] in_index = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_read_value;
  logic [1:0]  out_status;
  logic [4:0]  out_element_count;
  logic [31:0] out_first_index;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  array_list_scoreboard board = new();
  bit calm = 1'b0;
  int stall_left = 0;

  // per-phase register settings for the random part
  logic [4:0]  phase_cap   [10] = '{5'd1, 5'd8, 5'd9, 5'd12, 5'd0,
                                    5'd16, 5'd31, 5'd17, 5'd2, 5'd5};
  logic [15:0] phase_start [10] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h1234,
                                    16'h8001, 16'h0001, 16'hC000, 16'h7FF0, 16'h0000};
  bit          phase_calm  [10] = '{0, 0, 1, 0, 0, 0, 1, 0, 0, 0};

  insertion_shift_array DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_index         (in_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_value   (out_read_value),
    .out_status       (out_status),
    .out_element_count(out_element_count),
    .out_first_index  (out_first_index),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // note each accepted transaction on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      board.apply_request(op_t'(in_operation), in_index, in_value);
    if (rst_n && out_valid && !out_stall)
      board.check_result({out_read_value, out_status, out_element_count, out_first_index});
  end

  // one request transaction, returns right after the accepting edge
  task automatic send_request(op_t op, logic [31:0] idx, logic [31:0] val);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_index <= idx;
    in_value <= val;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // apb write: setup phase, access phase, then idle
  task automatic write_register(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    board.write_reg(addr, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every predicted response has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    // let the accepting edge pass first so the last accepted request is already noted
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // random request aimed mostly at the live window
  task automatic random_request();
    op_t         op;
    logic [31:0] idx;
    logic [31:0] val;
    int          r;
    int          usable;
    r = $urandom_range(0, 9);
    op = (r < 4) ? OP_READ : (r < 6) ? OP_APPEND : (r < 8) ? OP_PREPEND : OP_INSERT;
    usable = (board.capacity > SLOTS) ? SLOTS : board.capacity;
    if ($urandom_range(0, 9) < 3)
      idx = $urandom();
    else if (op == OP_INSERT)
      idx = board.base_index + $urandom_range(0, board.stored + 2) - 1;
    else
      idx = board.base_index + $urandom_range(0, usable + 1) - 1;
    r = $urandom_range(0, 19);
    val = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom();
    send_request(op, idx, val);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty array at reset settings: read window and insert range edges
    send_request(OP_READ, 32'd0, 32'd0);
    send_request(OP_READ, -32'sd1, 32'd0);
    send_request(OP_READ, 32'd16, 32'd0);
    send_request(OP_READ, 32'd15, 32'd0);
    send_request(OP_READ, 32'h8000_0000, 32'd0);
    send_request(OP_READ, 32'h7FFF_FFFF, 32'd0);
    send_request(OP_INSERT, 32'd1, 32'h1111_1111);
    send_request(OP_INSERT, -32'sd1, 32'h2222_2222);
    send_request(OP_INSERT, 32'd0, 32'hFFFF_FFFF);
    send_request(OP_APPEND, 32'd0, 32'h0000_0000);
    send_request(OP_PREPEND, 32'd0, 32'hA5A5_A5A5);
    // base is now -1: insert in the middle, then at the tail
    send_request(OP_INSERT, 32'd0, 32'h5A5A_5A5A);
    send_request(OP_INSERT, 32'd3, 32'h0F0F_0F0F);
    send_request(OP_READ, -32'sd1, 32'd0);
    send_request(OP_READ, 32'd2, 32'd0);

    // capacity zero: every push full, every read out of range
    drain_results();
    write_register(ADDR_CAPACITY, 32'd0);
    send_request(OP_APPEND, 32'd0, 32'hDEAD_BEEF);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 32'hDEAD_BEEF);
    send_request(OP_READ, -32'sd1, 32'd0);

    // capacity below the count: stored data stays, pushes full
    drain_results();
    write_register(ADDR_CAPACITY, 32'd3);
    send_request(OP_PREPEND, 32'd0, 32'hCAFE_0001);
    send_request(OP_READ, 32'd1, 32'd0);
    send_request(OP_READ, 32'd2, 32'd0);

    // most negative start index, then capacity above depth
    drain_results();
    write_register(ADDR_START_INDEX, 32'h0000_8000);
    send_request(OP_READ, -32'sd32768, 32'd0);
    drain_results();
    write_register(ADDR_CAPACITY, 32'd31);
    send_request(OP_READ, -32'sd32753, 32'd0);
    send_request(OP_READ, -32'sd32752, 32'd0);
    send_request(OP_APPEND, 32'd0, 32'h8000_0001);

    // most positive start index, read at the top of the window
    drain_results();
    write_register(ADDR_START_INDEX, 32'h0000_7FFF);
    send_request(OP_READ, 32'd32782, 32'd0);

    // random phases over a spread of register settings
    for (int p = 0; p < 10; p++) begin
      drain_results();
      write_register(ADDR_CAPACITY, {27'd0, phase_cap[p]});
      write_register(ADDR_START_INDEX, {16'd0, phase_start[p]});
      calm = phase_calm[p];
      repeat (132) random_request();
    end
    calm = 1'b0;

    drain_results();
    repeat (4) @(posedge clk);
    $display("ran %0d reads, %0d appends, %0d prepends, %0d inserts over many settings",
             board.op_seen[OP_READ], board.op_seen[OP_APPEND],
             board.op_seen[OP_PREPEND], board.op_seen[OP_INSERT]);
    $display("statuses: %0d ok, %0d full, %0d out of range; %0d results compared",
             board.status_seen[ST_OK], board.status_seen[ST_FULL],
             board.status_seen[ST_RANGE], board.checked);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/isa_pkg.sv
rtl/core/isa_cell.sv
rtl/core/insertion_shift_array.sv
dv/tb_insertion_shift_array.sv
